// ===== rtl/core/rinf_pkg.sv =====
// Shared types, constants and priority tables for the regex infix-to-postfix converter.
// Depends on nothing; every module of the block imports it.
package rinf_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int MAX_RESULTS = 34;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] OP_OPEN = 2'd0;
  localparam logic [1:0] OP_STAR = 2'd1;
  localparam logic [1:0] OP_ALT  = 2'd2;
  localparam logic [1:0] OP_CAT  = 2'd3;

  localparam logic [2:0] CL_OPERAND = 3'd0;
  localparam logic [2:0] CL_OPEN    = 3'd1;
  localparam logic [2:0] CL_STAR    = 3'd2;
  localparam logic [2:0] CL_ALT     = 3'd3;
  localparam logic [2:0] CL_CLOSE   = 3'd4;
  localparam logic [2:0] CL_BAD     = 3'd5;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR    = 3'd1;
  localparam logic [2:0] ERR_STRAY_CLOSE = 3'd2;
  localparam logic [2:0] ERR_OPEN_AT_END = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW    = 3'd4;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CAT   = 8'h2B;
  localparam logic [7:0] CH_ALT   = 8'h7C;

  localparam logic [3:0] PRIO_CAT_IN = 4'd2;

  typedef struct packed {
    logic [7:0] symbol;
    logic [2:0] cls;
    logic       join_cat;
    logic       last;
  } tok_t;

  function automatic logic [3:0] stack_prio(input logic [1:0] op);
    logic [3:0] p;
    case (op)
      OP_OPEN: p = 4'd1;
      OP_STAR: p = 4'd7;
      OP_ALT:  p = 4'd5;
      default: p = 4'd3;
    endcase
    return p;
  endfunction

  function automatic logic [3:0] in_prio(input logic [2:0] cls);
    logic [3:0] p;
    case (cls)
      CL_OPEN: p = 4'd8;
      CL_STAR: p = 4'd6;
      CL_ALT:  p = 4'd4;
      default: p = 4'd1;
    endcase
    return p;
  endfunction

  function automatic logic [1:0] cls_op(input logic [2:0] cls);
    logic [1:0] o;
    case (cls)
      CL_OPEN: o = OP_OPEN;
      CL_STAR: o = OP_STAR;
      CL_ALT:  o = OP_ALT;
      default: o = OP_CAT;
    endcase
    return o;
  endfunction

  function automatic logic [7:0] op_char(input logic [1:0] op);
    logic [7:0] c;
    case (op)
      OP_OPEN: c = CH_OPEN;
      OP_STAR: c = CH_STAR;
      OP_ALT:  c = CH_ALT;
      default: c = CH_CAT;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/rinf_front.sv =====
// Front end: accepts input characters, classifies them and marks implied concatenation.
// Depends on rinf_pkg; feeds tokens into rinf_queue.
module rinf_front import rinf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol
  input  logic       s_tlast,   // is_last
  input  logic       q_full,
  output logic       q_push,
  output tok_t       q_tok
);

  logic [7:0] prev_char;
  logic       has_prev;
  logic [2:0] cls;
  logic       join_cat;

  always_comb begin
    if (s_tdata inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) begin
      cls = CL_OPERAND;
    end else begin
      case (s_tdata)
        CH_OPEN:  cls = CL_OPEN;
        CH_CLOSE: cls = CL_CLOSE;
        CH_STAR:  cls = CL_STAR;
        CH_ALT:   cls = CL_ALT;
        default:  cls = CL_BAD;
      endcase
    end
  end

  // Adjacency implies a concatenation before an operand or an opening bracket.
  assign join_cat = has_prev &&
                    (((cls == CL_OPERAND) && (prev_char != CH_OPEN) && (prev_char != CH_ALT)) ||
                     ((cls == CL_OPEN) && (prev_char != CH_ALT) && (prev_char != CH_OPEN)));

  assign s_tready       = !q_full;
  assign q_push         = s_tvalid && !q_full;
  assign q_tok.symbol   = s_tdata;
  assign q_tok.cls      = cls;
  assign q_tok.join_cat = join_cat;
  assign q_tok.last     = s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_char <= 8'd0;
      has_prev  <= 1'b0;
    end else if (q_push) begin
      if (s_tlast) begin
        prev_char <= 8'd0;
        has_prev  <= 1'b0;
      end else if (cls != CL_BAD) begin
        prev_char <= s_tdata;
        has_prev  <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/rinf_queue.sv =====
// Two-entry token queue between the front end and the stack engine.
// Depends on rinf_pkg for the token type.
module rinf_queue import rinf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tok_t push_tok,
  input  logic pop,
  output tok_t head,
  output logic full,
  output logic empty
);

  tok_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] level;

  assign full  = (level == 2'd2);
  assign empty = (level == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        level <= level + 2'd1;
      end else if (pop && !push) begin
        level <= level - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/rinf_back.sv =====
// Back end: operator stack engine and output register, one stack step per cycle
// when not stalled. Depends on rinf_pkg; takes tokens from rinf_queue.
module rinf_back import rinf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  tok_t        head,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_symbol, [10:8] error_code, rest zero
  output logic        m_tuser,   // has_symbol
  output logic        m_tlast    // end_of_run
);

  localparam logic [1:0] PH_CAT    = 2'd0;
  localparam logic [1:0] PH_MAIN   = 2'd1;
  localparam logic [1:0] PH_FLUSH  = 2'd2;
  localparam logic [1:0] PH_STATUS = 2'd3;

  logic [1:0]       stack [STACK_DEPTH];
  logic [CNT_W-1:0] count, count_next;
  logic [2:0]       err, err_next;
  logic [1:0]       phase, phase_next;
  logic [RES_W-1:0] res_cnt, res_next;

  logic [1:0]       cur_phase;
  logic [CNT_W-1:0] top_idx;
  logic [1:0]       top_op;
  logic [3:0]       tp;
  logic [3:0]       f_in;
  logic [1:0]       f_op;
  logic             f_close;
  logic             res_full, can_emit;
  logic             push, emit, emit_fire, step_ok, step_err, fin;
  logic [7:0]       emit_sym;
  logic             emit_has, emit_end;
  logic [2:0]       emit_err;
  logic [7:0]       out_sym;
  logic [2:0]       out_err;

  assign cur_phase = ((phase == PH_CAT) && !head.join_cat) ? PH_MAIN : phase;
  assign top_idx   = count - CNT_W'(1);
  assign top_op    = stack[top_idx[IDX_W-1:0]];
  assign tp        = (count == '0) ? 4'd0 : stack_prio(top_op);
  assign res_full  = (res_cnt >= RES_W'(MAX_RESULTS));
  // Results beyond the per-item limit are dropped, so they never wait for the port.
  assign can_emit  = !m_tvalid || m_tready || res_full;

  always_comb begin
    if (cur_phase == PH_CAT) begin
      f_in    = PRIO_CAT_IN;
      f_op    = OP_CAT;
      f_close = 1'b0;
    end else begin
      f_in    = in_prio(head.cls);
      f_op    = cls_op(head.cls);
      f_close = (head.cls == CL_CLOSE);
    end
  end

  always_comb begin
    count_next = count;
    err_next   = err;
    phase_next = phase;
    res_next   = res_cnt;
    push       = 1'b0;
    emit       = 1'b0;
    emit_sym   = 8'd0;
    emit_has   = 1'b1;
    emit_end   = 1'b0;
    emit_err   = ERR_NONE;
    step_ok    = 1'b0;
    step_err   = 1'b0;
    fin        = 1'b0;
    if (!q_empty) begin
      case (cur_phase)
        PH_CAT, PH_MAIN: begin
          if (err != ERR_NONE) begin
            step_err = 1'b1;
          end else if ((cur_phase == PH_MAIN) && (head.cls == CL_OPERAND)) begin
            if (can_emit) begin
              emit     = 1'b1;
              emit_sym = head.symbol;
              step_ok  = 1'b1;
            end
          end else if ((cur_phase == PH_MAIN) && (head.cls == CL_BAD)) begin
            err_next = ERR_BAD_CHAR;
            step_err = 1'b1;
          end else if (tp < f_in) begin
            if (f_close) begin
              err_next = ERR_STRAY_CLOSE;
              step_err = 1'b1;
            end else if (count >= CNT_W'(STACK_DEPTH)) begin
              err_next = ERR_OVERFLOW;
              step_err = 1'b1;
            end else begin
              push       = 1'b1;
              count_next = count + CNT_W'(1);
              step_ok    = 1'b1;
            end
          end else if (tp > f_in) begin
            if (can_emit) begin
              emit       = 1'b1;
              emit_sym   = op_char(top_op);
              count_next = top_idx;
            end
          end else begin
            // A closing bracket meets its opening bracket: both vanish.
            count_next = top_idx;
            step_ok    = 1'b1;
          end
        end
        PH_FLUSH: begin
          if (count == '0) begin
            phase_next = PH_STATUS;
          end else if (top_op == OP_OPEN) begin
            err_next   = ERR_OPEN_AT_END;
            phase_next = PH_STATUS;
          end else if (can_emit) begin
            emit       = 1'b1;
            emit_sym   = op_char(top_op);
            count_next = top_idx;
          end
        end
        PH_STATUS: begin
          if (can_emit) begin
            emit       = 1'b1;
            emit_has   = 1'b0;
            emit_end   = 1'b1;
            emit_err   = err;
            count_next = '0;
            err_next   = ERR_NONE;
            fin        = 1'b1;
          end
        end
        default: begin
          phase_next = PH_CAT;
        end
      endcase
    end
    if (step_ok) begin
      if (cur_phase == PH_CAT) begin
        phase_next = PH_MAIN;
      end else if (head.last) begin
        phase_next = PH_FLUSH;
      end else begin
        fin = 1'b1;
      end
    end
    if (step_err) begin
      if (head.last) begin
        phase_next = PH_STATUS;
      end else begin
        fin = 1'b1;
      end
    end
    if (emit && !res_full) begin
      res_next = res_cnt + RES_W'(1);
    end
    if (fin) begin
      phase_next = PH_CAT;
      res_next   = '0;
    end
  end

  assign emit_fire = emit && !res_full;
  assign q_pop     = fin;

  always_ff @(posedge clk) begin
    if (push) begin
      stack[count[IDX_W-1:0]] <= f_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      err      <= ERR_NONE;
      phase    <= PH_CAT;
      res_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count   <= count_next;
      err     <= err_next;
      phase   <= phase_next;
      res_cnt <= res_next;
      if (emit_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_sym <= emit_sym;
      out_err <= emit_err;
      m_tuser <= emit_has;
      m_tlast <= emit_end;
    end
  end

  assign m_tdata = {5'd0, out_err, out_sym};

endmodule

// ===== rtl/core/regex_infix_to_postfix.sv =====
// Regular-expression infix to postfix converter: top level.
// Uses rinf_pkg, rinf_front, rinf_queue and rinf_back.
//
// The slave stream takes one ASCII character per word in s_tdata, with s_tlast on
// the final character of an expression. The master stream returns the postfix form:
// operands and the operators '+', '|' and '*', one per word with m_tuser high. Each
// expression ends with one status word (m_tuser low, m_tlast high) whose error code
// is zero, or reports a bad character, a stray ')', an open '(' or stack overflow.
// After an error, the remaining characters of that expression give no words.
// A character enters a two-entry queue in the cycle it is accepted; the stack engine
// then works through it in steps: an implied concatenation, the character itself,
// every operator popped, and on the last character each flushed operator, a check
// that finds the stack empty or an open '(' and the status word. The queue can take
// new characters while the engine still works on earlier ones; the single-step
// operator stack limits the rate. With the engine idle, the earliest result of a
// character passes through the queue and the output register, after a stack step
// for an implied concatenation if one is pushed first.
// Reset empties the queue, the stack and the output register. When the receiver
// stalls, the output register holds its word, the engine waits, and the queue keeps
// accepting until it is full.
module regex_infix_to_postfix import rinf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic        s_tlast,   // is_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_symbol, [10:8] error_code, rest zero
  output logic        m_tuser,   // has_symbol
  output logic        m_tlast    // end_of_run
);

  logic q_push, q_pop, q_full, q_empty;
  tok_t q_tok, q_head;

  rinf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_tok    (q_tok)
  );

  rinf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_tok (q_tok),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  rinf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== test/rinf_postfix_check.sv =====
// Checker for the regex infix-to-postfix converter: predicts the postfix words of each
// accepted character and compares them with the master stream. Depends on rinf_pkg.
`timescale 1ns / 1ps

module rinf_postfix_check import rinf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic        s_tlast,   // is_last
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [7:0] out_symbol, [10:8] error_code, rest zero
  input  logic        m_tuser,   // has_symbol
  input  logic        m_tlast,   // end_of_run
  output int          fails,
  output int          pending,
  output int          words_seen,
  output int          runs_clean,
  output int          runs_flagged
);

  // A closing parenthesis is fed to the stack as a fifth token kind.
  localparam logic [2:0] TOK_CLOSE = 3'd4;

  localparam logic [3:0] IN_OPEN  = 4'd8;
  localparam logic [3:0] IN_STAR  = 4'd6;
  localparam logic [3:0] IN_ALT   = 4'd4;
  localparam logic [3:0] IN_CAT   = 4'd2;
  localparam logic [3:0] IN_CLOSE = 4'd1;

  typedef struct packed {
    logic [7:0] sym;
    logic       has;
    logic       fin;
    logic [2:0] code;
  } postfix_word_t;

  postfix_word_t expected_postfix[$];
  postfix_word_t want;

  logic [7:0] last_char;
  logic       seen_char;
  logic [1:0] op_stack [STACK_DEPTH];
  int         depth;
  logic [2:0] err_code;
  int         emitted;

  int n_fail   = 0;
  int n_words  = 0;
  int n_clean  = 0;
  int n_flag   = 0;

  function automatic logic is_operand(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
  endfunction

  function automatic logic [3:0] held_rank(input logic [1:0] op);
    logic [3:0] r;
    r = 4'd3;
    if (op == OP_OPEN) r = 4'd1;
    else if (op == OP_STAR) r = 4'd7;
    else if (op == OP_ALT) r = 4'd5;
    return r;
  endfunction

  function automatic logic [7:0] op_symbol(input logic [1:0] op);
    logic [7:0] c;
    c = CH_CAT;
    if (op == OP_OPEN) c = CH_OPEN;
    else if (op == OP_STAR) c = CH_STAR;
    else if (op == OP_ALT) c = CH_ALT;
    return c;
  endfunction

  function automatic logic [3:0] top_rank();
    if (depth == 0) return 4'd0;
    return held_rank(op_stack[depth - 1]);
  endfunction

  task automatic push_word(input logic [7:0] sym, input logic has, input logic fin,
                           input logic [2:0] code);
    postfix_word_t w;
    w = '{sym: sym, has: has, fin: fin, code: code};
    if (emitted < MAX_RESULTS) begin
      expected_postfix.push_back(w);
      emitted++;
    end
  endtask

  task automatic clear_state();
    last_char = 8'd0;
    seen_char = 1'b0;
    depth     = 0;
    err_code  = ERR_NONE;
  endtask

  // Pops every operator that outranks the incoming token, then pushes it or flags a
  // stray ')' or overflow. A '(' on top meeting ')' has equal rank and is dropped.
  task automatic feed_op(input logic [2:0] tok, input logic [3:0] rank);
    logic [3:0] tr;
    bit         done;
    done = 1'b0;
    while (!done) begin
      tr = top_rank();
      if (tr < rank) begin
        if (tok == TOK_CLOSE) err_code = ERR_STRAY_CLOSE;
        else if (depth >= STACK_DEPTH) err_code = ERR_OVERFLOW;
        else begin
          op_stack[depth] = tok[1:0];
          depth++;
        end
        done = 1'b1;
      end else if (tr > rank) begin
        depth--;
        push_word(op_symbol(op_stack[depth]), 1'b1, 1'b0, ERR_NONE);
      end else begin
        depth--;
        done = 1'b1;
      end
    end
  endtask

  task automatic flush_stack();
    bit done;
    done = 1'b0;
    while (!done && depth > 0) begin
      if (op_stack[depth - 1] == OP_OPEN) begin
        err_code = ERR_OPEN_AT_END;
        done = 1'b1;
      end else begin
        depth--;
        push_word(op_symbol(op_stack[depth]), 1'b1, 1'b0, ERR_NONE);
      end
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    logic operand;
    logic join_cat;
    operand = is_operand(c);
    if (!operand && c != CH_OPEN && c != CH_CLOSE && c != CH_STAR && c != CH_ALT) begin
      err_code = ERR_BAD_CHAR;
      return;
    end
    if (seen_char) begin
      join_cat = (last_char != CH_OPEN && last_char != CH_ALT && operand) ||
                 (c == CH_OPEN && last_char != CH_ALT && last_char != CH_OPEN);
      if (join_cat) begin
        feed_op({1'b0, OP_CAT}, IN_CAT);
        if (err_code != ERR_NONE) return;
      end
    end
    last_char = c;
    seen_char = 1'b1;
    if (operand) push_word(c, 1'b1, 1'b0, ERR_NONE);
    else if (c == CH_OPEN) feed_op({1'b0, OP_OPEN}, IN_OPEN);
    else if (c == CH_STAR) feed_op({1'b0, OP_STAR}, IN_STAR);
    else if (c == CH_ALT) feed_op({1'b0, OP_ALT}, IN_ALT);
    else feed_op(TOK_CLOSE, IN_CLOSE);
  endtask

  task automatic predict_postfix(input logic [7:0] c, input logic is_last);
    emitted = 0;
    if (err_code == ERR_NONE) take_char(c);
    if (is_last) begin
      if (err_code == ERR_NONE) flush_stack();
      push_word(8'd0, 1'b0, 1'b1, err_code);
      clear_state();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_postfix.delete();
    end else begin
      // Outputs are checked before the new character is predicted; a word leaving
      // the block at this edge always belongs to an earlier character.
      if (m_tvalid && m_tready) begin
        n_words++;
        if (expected_postfix.size() == 0) begin
          $error("unexpected word: data %h user %b last %b", m_tdata, m_tuser, m_tlast);
          n_fail++;
        end else begin
          want = expected_postfix.pop_front();
          if (m_tdata[7:0] !== want.sym) begin
            $error("out_symbol: expected %h, got %h", want.sym, m_tdata[7:0]);
            n_fail++;
          end
          if (m_tuser !== want.has) begin
            $error("has_symbol: expected %b, got %b", want.has, m_tuser);
            n_fail++;
          end
          if (m_tlast !== want.fin) begin
            $error("end_of_run: expected %b, got %b", want.fin, m_tlast);
            n_fail++;
          end
          if (m_tdata[10:8] !== want.code) begin
            $error("error_code: expected %0d, got %0d", want.code, m_tdata[10:8]);
            n_fail++;
          end
          if (want.fin) begin
            if (want.code == ERR_NONE) n_clean++;
            else n_flag++;
          end
        end
      end
      if (s_tvalid && s_tready) predict_postfix(s_tdata, s_tlast);
    end
    fails        <= n_fail;
    pending      <= expected_postfix.size();
    words_seen   <= n_words;
    runs_clean   <= n_clean;
    runs_flagged <= n_flag;
  end

endmodule

// ===== test/tb_regex_infix_to_postfix.sv =====
// Testbench top for the regex infix-to-postfix converter: clock, reset, stimulus and
// verdict. Depends on rinf_pkg, regex_infix_to_postfix and rinf_postfix_check.
`timescale 1ns / 1ps

module tb_regex_infix_to_postfix import rinf_pkg::*;;

  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 16;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'd0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int fails, pending, words_seen, runs_clean, runs_flagged;

  bit         idle_on    = 1'b1;
  int         rest_left  = 0;
  int         quiet      = 0;
  int         items_sent = 0;
  int         exprs_sent = 0;
  logic [7:0] expr_buf[$];

  regex_infix_to_postfix u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  rinf_postfix_check u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .fails(fails), .pending(pending), .words_seen(words_seen),
    .runs_clean(runs_clean), .runs_flagged(runs_flagged)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver side: stalls come in random bursts.
  always @(posedge clk) begin
    if (rest_left > 0) begin
      m_tready  <= 1'b0;
      rest_left <= rest_left - 1;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      m_tready  <= 1'b0;
      rest_left <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Any correct run accepts a word on one side or the other every few cycles.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [7:0] pick_operand();
    logic [7:0] base;
    case ($urandom_range(0, 2))
      0:       base = "a" + 8'($urandom_range(0, 25));
      1:       base = "A" + 8'($urandom_range(0, 25));
      default: base = "0" + 8'($urandom_range(0, 9));
    endcase
    return base;
  endfunction

  // The word is left on the bus once accepted; the next call either replaces it
  // in the same step or lowers tvalid for an idle burst.
  task automatic send_char(input logic [7:0] c, input logic is_last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (is_last) exprs_sent++;
  endtask

  task automatic send_buf(input bit rand_last);
    logic l;
    for (int i = 0; i < expr_buf.size(); i++) begin
      l = rand_last ? ($urandom_range(0, 3) == 0) : (i == expr_buf.size() - 1);
      send_char(expr_buf[i], l);
    end
    expr_buf.delete();
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Builds a balanced expression: operands, groups, closures and alternations.
  task automatic gen_wellformed(input int len);
    int  open;
    bit  need_operand;
    int  r;
    open = 0;
    need_operand = 1'b1;
    for (int i = 0; i < len; i++) begin
      if (need_operand) begin
        if ($urandom_range(0, 3) == 0 && open < 6) begin
          expr_buf.push_back(CH_OPEN);
          open++;
        end else begin
          expr_buf.push_back(pick_operand());
          need_operand = 1'b0;
        end
      end else begin
        r = $urandom_range(0, 9);
        if (r == 4 && open < 6) begin
          expr_buf.push_back(CH_OPEN);
          open++;
          need_operand = 1'b1;
        end else if (r == 5 || r == 6) begin
          expr_buf.push_back(CH_STAR);
        end else if (r == 7) begin
          expr_buf.push_back(CH_ALT);
          need_operand = 1'b1;
        end else if (r >= 8 && open > 0) begin
          expr_buf.push_back(CH_CLOSE);
          open--;
        end else begin
          expr_buf.push_back(pick_operand());
        end
      end
    end
    if (need_operand) expr_buf.push_back(pick_operand());
    repeat (open) expr_buf.push_back(CH_CLOSE);
  endtask

  task automatic gen_broken();
    int pos;
    gen_wellformed($urandom_range(2, 12));
    pos = $urandom_range(0, expr_buf.size() - 1);
    case ($urandom_range(0, 4))
      0:       expr_buf[pos] = CH_CLOSE;
      1:       expr_buf.insert(pos, CH_OPEN);
      2:       expr_buf[pos] = 8'($urandom_range(0, 255));
      3:       expr_buf[pos] = ($urandom_range(0, 1) == 0) ? CH_ALT : CH_STAR;
      default: expr_buf.push_front(CH_CLOSE);
    endcase
  endtask

  // Deep nesting runs the stack to its limit and, often, past it.
  task automatic gen_deep();
    int  n_open;
    bit  paired;
    paired = $urandom_range(0, 1);
    n_open = paired ? $urandom_range(14, 18) : $urandom_range(29, 34);
    for (int k = 0; k < n_open; k++) begin
      if (paired) expr_buf.push_back(pick_operand());
      expr_buf.push_back(CH_OPEN);
    end
    expr_buf.push_back(pick_operand());
    repeat ($urandom_range(0, n_open)) expr_buf.push_back(CH_CLOSE);
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 8)) expr_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int  start_items;
    bit  paused_once;
    int  kind;
    paused_once = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: single operand, every operator, operand extremes, the bad
    // character, stray ')' and open '(' errors, plus the byte extremes.
    load_text("a");        send_buf(1'b0);
    load_text("(a|Z)*09"); send_buf(1'b0);
    load_text("a#b");      send_buf(1'b0);
    load_text(")");        send_buf(1'b0);
    load_text("(z|A");     send_buf(1'b0);
    load_text("9*|A");     send_buf(1'b0);
    expr_buf.push_back(8'h00);
    send_buf(1'b0);
    expr_buf.push_back(8'hFF);
    send_buf(1'b0);
    wait_for_drain();

    start_items = items_sent;
    while (items_sent < start_items + RANDOM_ITEMS) begin
      if (!paused_once && items_sent >= start_items + RANDOM_ITEMS / 2) begin
        wait_for_drain();
        paused_once = 1'b1;
      end
      if (items_sent >= start_items + RANDOM_ITEMS * 85 / 100) idle_on = 1'b0;
      kind = $urandom_range(0, 19);
      if (kind <= 13) begin
        gen_wellformed($urandom_range(1, 14));
        send_buf(1'b0);
      end else if (kind <= 16) begin
        gen_broken();
        send_buf(1'b0);
      end else if (kind <= 18) begin
        gen_noise();
        send_buf(1'b1);
      end else begin
        gen_deep();
        send_buf(1'b0);
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d expressions: balanced, corrupted, deep and noise.",
             items_sent, exprs_sent);
    $display("Checked %0d output words; %0d expressions ended clean, %0d with an error.",
             words_seen, runs_clean, runs_flagged);
    if (fails == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rinf_pkg.sv
rtl/core/rinf_front.sv
rtl/core/rinf_queue.sv
rtl/core/rinf_back.sv
rtl/core/regex_infix_to_postfix.sv
test/rinf_postfix_check.sv
test/tb_regex_infix_to_postfix.sv
